@@ rtl/core/tmc_pkg.sv @@
// Shared types and constants of the memory request completer.
package tmc_pkg;

  typedef enum logic [2:0] {
    PH_HDR0     = 3'd0,
    PH_HDR1     = 3'd1,
    PH_HDR2     = 3'd2,
    PH_WDATA    = 3'd3,
    PH_CPL_HDR0 = 3'd4,
    PH_CPL_HDR1 = 3'd5,
    PH_CPL_HDR2 = 3'd6,
    PH_CPL_DATA = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_IGNORE = 2'd2
  } status_e;

  typedef enum logic {
    OP_WORD = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  localparam logic [31:0] CplHdr0    = 32'h4A00_0000;
  localparam logic [14:0] SplitSize  = 15'h4000;
  localparam logic [15:0] CplIdReset = 16'd220;

  // One result on its way to the output register.
  typedef struct packed {
    logic        valid;     // completion word present
    logic [31:0] word;      // header word, or zero
    logic        use_mem;   // data word comes from the byte banks
    logic [3:0]  en;        // byte enables of a data word
    logic        last;
    status_e     status;
    logic        pending;
  } meta_t;

endpackage

@@ rtl/core/tlp_memory_completer_core.sv @@
// Top level of the memory request completer: input transfer, bank read stage, output register.
//
//  channel  | direction | tdata                                  | tuser      | tlast
//  s_axis   | in        | packet_word[31:0]                      | operation  | -
//  m_axis   | out       | out_word, status, completion_pending   | out_valid  | out_last
//  cfg      | in        | completion source id via cfg_we_i/cfg_wdata_i | -   | -
//
// One item per cycle while the output takes results; each item gives one result,
// registered by the parse/bank read stage and then the output register. The
// single dword port of the byte banks sets the rate. Reset clears the parser
// and sets the completion source id to 220; the byte banks are not cleared. A
// stalled output holds the bank read stage and then the input.
module tlp_memory_completer_core import tmc_pkg::*; #(
  parameter int ADDR_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // packet_word
  input  logic        s_axis_tuser_i,  // operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // out_word[31:0], status[33:32], pending[34], zero
  output logic        m_axis_tuser_o,  // out_valid
  output logic        m_axis_tlast_o   // out_last
);

  meta_t                       meta, s1_q;
  logic                        s1_vld_q, out_vld_q;
  logic                        acc, s1_adv;
  logic [3:0]                  we;
  logic [3:0][ADDR_BITS-3:0]   wrow;
  logic [3:0][7:0]             wdata;
  logic                        re;
  logic [ADDR_BITS-3:0]        rrow;
  logic [31:0]                 rdata, mask, word_d;
  logic [31:0]                 word_q;
  status_e                     st_q;
  logic                        pend_q, ovld_q, last_q;

  assign s1_adv          = s1_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_vld_q || s1_adv;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  tmc_ctrl #(.ADDR_BITS(ADDR_BITS)) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .acc_i(acc), .op_i(s_axis_tuser_i), .word_i(s_axis_tdata_i),
    .meta_o(meta), .we_o(we), .wrow_o(wrow), .wdata_o(wdata),
    .re_o(re), .rrow_o(rrow)
  );

  tmc_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
    .clk_i, .we_i(we), .wrow_i(wrow), .wdata_i(wdata),
    .re_i(re), .rrow_i(rrow), .rdata_o(rdata)
  );

  always_comb begin
    for (int b = 0; b < 4; b++) mask[8*b +: 8] = {8{s1_q.en[b]}};
  end
  assign word_d = s1_q.use_mem ? (rdata & mask) : s1_q.word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (acc)         s1_vld_q <= 1'b1;
      else if (s1_adv) s1_vld_q <= 1'b0;
      if (s1_adv)                         out_vld_q <= 1'b1;
      else if (m_axis_tready_i)           out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) s1_q <= meta;
    if (s1_adv) begin
      word_q <= word_d;
      st_q   <= s1_q.status;
      pend_q <= s1_q.pending;
      ovld_q <= s1_q.valid;
      last_q <= s1_q.last;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'b0, pend_q, st_q, word_q};
  assign m_axis_tuser_o  = ovld_q;
  assign m_axis_tlast_o  = last_q;

`ifndef SYNTHESIS
  a_last_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("last flag without completion word");
  a_word_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[33:32] == ST_OK)
    else $error("completion word with non-ok status");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[31:0] == 32'd0)
    else $error("nonzero word without completion");
  a_read_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |-> we == 4'b0000)
    else $error("bank read and write in one cycle");
`endif

endmodule

@@ rtl/core/tmc_mem.sv @@
// Four byte-wide banks holding the byte store, one dword access per cycle.
module tmc_mem import tmc_pkg::*; #(
  parameter int ADDR_BITS = 20
) (
  input  logic                         clk_i,
  input  logic [3:0]                   we_i,
  input  logic [3:0][ADDR_BITS-3:0]    wrow_i,
  input  logic [3:0][7:0]              wdata_i,
  input  logic                         re_i,
  input  logic [ADDR_BITS-3:0]         rrow_i,
  output logic [31:0]                  rdata_o
);

  localparam int Depth = 2 ** (ADDR_BITS - 2);

  logic [7:0] bank0 [Depth];
  logic [7:0] bank1 [Depth];
  logic [7:0] bank2 [Depth];
  logic [7:0] bank3 [Depth];
  logic [3:0][7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i[0]) bank0[wrow_i[0]] <= wdata_i[0];
    if (we_i[1]) bank1[wrow_i[1]] <= wdata_i[1];
    if (we_i[2]) bank2[wrow_i[2]] <= wdata_i[2];
    if (we_i[3]) bank3[wrow_i[3]] <= wdata_i[3];
    if (re_i) begin
      rd_q[0] <= bank0[rrow_i];
      rd_q[1] <= bank1[rrow_i];
      rd_q[2] <= bank2[rrow_i];
      rd_q[3] <= bank3[rrow_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

@@ rtl/core/tmc_ctrl.sv @@
// Request parser and completion sequencer; drives the byte banks.
module tmc_ctrl import tmc_pkg::*; #(
  parameter int ADDR_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         acc_i,
  input  logic                         op_i,
  input  logic [31:0]                  word_i,
  output meta_t                        meta_o,
  output logic [3:0]                   we_o,
  output logic [3:0][ADDR_BITS-3:0]    wrow_o,
  output logic [3:0][7:0]              wdata_o,
  output logic                         re_o,
  output logic [ADDR_BITS-3:0]         rrow_o
);

  phase_e               phase_q, phase_d;
  logic                 is_wr_q, is_wr_d;
  logic [9:0]           len_q, len_d;
  logic [15:0]          req_q, req_d;
  logic [7:0]           tag_q, tag_d;
  logic [3:0]           fe_q, fe_d, le_q, le_d;
  logic [ADDR_BITS-1:0] cur_q, cur_d;
  logic [9:0]           widx_q, widx_d;
  logic [11:0]          bytes_q, bytes_d;
  logic [9:0]           chunk_q, chunk_d;
  logic                 halt_q, halt_d;
  logic [15:0]          cid_q;

  logic [3:0]  en;
  logic [33:0] end_w;
  logic [31:0] cur_ext;
  logic [14:0] room;
  logic [11:0] chunk_b;
  logic [9:0]  chunk_nx;
  logic [ADDR_BITS-3:0] row_base;

  always_comb begin
    if (widx_q == 10'd0)             en = fe_q;
    else if (widx_q + 10'd1 == len_q) en = le_q;
    else                              en = 4'hF;
  end

  assign end_w    = {2'b0, word_i} + {22'b0, len_q, 2'b00};
  assign cur_ext  = 32'(cur_q);
  assign room     = SplitSize - {1'b0, cur_ext[13:0]};
  assign chunk_b  = ({3'b0, bytes_q} < room) ? bytes_q : room[11:0];
  assign row_base = cur_q[ADDR_BITS-1:2];

  // Unaligned writes straddle two rows: lower banks take the next row.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [1:0] c;
      c          = 2'(b) - cur_q[1:0];
      wrow_o[b]  = row_base + (ADDR_BITS-2)'((2'(b) < cur_q[1:0]) ? 1'b1 : 1'b0);
      wdata_o[b] = word_i[8*c +: 8];
      we_o[b]    = acc_i && !halt_q && op_i == OP_WORD && phase_q == PH_WDATA && en[c];
    end
  end

  assign re_o   = acc_i && !halt_q && op_i == OP_PULL && phase_q == PH_CPL_DATA;
  assign rrow_o = row_base;

  always_comb begin
    phase_d  = phase_q;
    is_wr_d  = is_wr_q;
    len_d    = len_q;
    req_d    = req_q;
    tag_d    = tag_q;
    fe_d     = fe_q;
    le_d     = le_q;
    cur_d    = cur_q;
    widx_d   = widx_q;
    bytes_d  = bytes_q;
    chunk_d  = chunk_q;
    halt_d   = halt_q;
    chunk_nx = 10'd0;
    meta_o   = '0;
    meta_o.status = ST_OK;
    if (halt_q) begin
      meta_o.status = ST_IGNORE;
    end else if (op_i == OP_PULL) begin
      case (phase_q)
        PH_CPL_HDR0: begin
          chunk_d      = chunk_b[11:2];
          meta_o.valid = 1'b1;
          meta_o.word  = CplHdr0 | {22'b0, chunk_b[11:2]};
          phase_d      = PH_CPL_HDR1;
        end
        PH_CPL_HDR1: begin
          meta_o.valid = 1'b1;
          meta_o.word  = {cid_q, 4'b0, bytes_q};
          phase_d      = PH_CPL_HDR2;
        end
        PH_CPL_HDR2: begin
          meta_o.valid = 1'b1;
          meta_o.word  = {req_q, tag_q, 1'b0, cur_ext[6:0]};
          phase_d      = PH_CPL_DATA;
        end
        PH_CPL_DATA: begin
          meta_o.valid   = 1'b1;
          meta_o.use_mem = 1'b1;
          meta_o.en      = en;
          cur_d          = cur_q + ADDR_BITS'(4);
          widx_d         = widx_q + 10'd1;
          bytes_d        = (bytes_q >= 12'd4) ? bytes_q - 12'd4 : 12'd0;
          chunk_nx       = (chunk_q != 10'd0) ? chunk_q - 10'd1 : 10'd0;
          chunk_d        = chunk_nx;
          if (chunk_nx == 10'd0) begin
            if (bytes_d == 12'd0) begin
              meta_o.last = 1'b1;
              phase_d     = PH_HDR0;
            end else begin
              phase_d     = PH_CPL_HDR0;
            end
          end
        end
        default: meta_o.status = ST_IGNORE;
      endcase
    end else begin
      case (phase_q)
        PH_HDR0: begin
          if (word_i[31:30] == 2'b01) begin
            is_wr_d = 1'b1;
            len_d   = word_i[9:0];
            phase_d = PH_HDR1;
          end else if (word_i[31:10] == 22'd0) begin
            is_wr_d = 1'b0;
            len_d   = word_i[9:0];
            phase_d = PH_HDR1;
          end else begin
            meta_o.status = ST_REJECT;
            halt_d        = 1'b1;
          end
        end
        PH_HDR1: begin
          req_d   = word_i[31:16];
          tag_d   = word_i[15:8];
          le_d    = word_i[7:4];
          fe_d    = word_i[3:0];
          phase_d = PH_HDR2;
        end
        PH_HDR2: begin
          if ((end_w >> ADDR_BITS) != 34'd0 || (!is_wr_q && word_i[1:0] != 2'b00)) begin
            meta_o.status = ST_REJECT;
            halt_d        = 1'b1;
            phase_d       = PH_HDR0;
          end else begin
            cur_d  = word_i[ADDR_BITS-1:0];
            widx_d = 10'd0;
            if (len_q == 10'd0) begin
              phase_d = PH_HDR0;
            end else if (is_wr_q) begin
              phase_d = PH_WDATA;
            end else begin
              bytes_d = {len_q, 2'b00};
              chunk_d = 10'd0;
              phase_d = PH_CPL_HDR0;
            end
          end
        end
        PH_WDATA: begin
          cur_d  = cur_q + ADDR_BITS'(4);
          widx_d = widx_q + 10'd1;
          if (widx_d >= len_q) phase_d = PH_HDR0;
        end
        default: meta_o.status = ST_IGNORE;  // completions still pending
      endcase
    end
    meta_o.pending = !halt_d && phase_d[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      is_wr_q <= 1'b0;
      len_q   <= '0;
      req_q   <= '0;
      tag_q   <= '0;
      fe_q    <= '0;
      le_q    <= '0;
      cur_q   <= '0;
      widx_q  <= '0;
      bytes_q <= '0;
      chunk_q <= '0;
      halt_q  <= 1'b0;
      cid_q   <= CplIdReset;
    end else begin
      if (cfg_we_i) cid_q <= cfg_wdata_i;
      if (acc_i) begin
        phase_q <= phase_d;
        is_wr_q <= is_wr_d;
        len_q   <= len_d;
        req_q   <= req_d;
        tag_q   <= tag_d;
        fe_q    <= fe_d;
        le_q    <= le_d;
        cur_q   <= cur_d;
        widx_q  <= widx_d;
        bytes_q <= bytes_d;
        chunk_q <= chunk_d;
        halt_q  <= halt_d;
      end
    end
  end

endmodule
